// ----- hdl/weight_stationary_systolic_tile_top_assert.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the systolic tile bank
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef WEIGHT_STATIONARY_SYSTOLIC_TILE_TOP_ASSERT_SVH
`define WEIGHT_STATIONARY_SYSTOLIC_TILE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define WSST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsst check failed");

// next-cycle implication, off during reset
`define WSST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsst check failed");

// next-cycle implication, live through reset
`define WSST_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wsst check failed");

`endif

// ----- hdl/wsst_pkg.sv -----
// ----------------------------------------------------------------------------
// wsst_pkg
// shared types and defaults for the systolic tile bank
// ----------------------------------------------------------------------------
package wsst_pkg;

  localparam int ARRAY_DIM_DEF        = 8;
  localparam int ACTS_PER_WORD_DEF    = 4;
  localparam int WEIGHTS_PER_WORD_DEF = 4;
  localparam int ACT_WIDTH_DEF        = 8;
  localparam int WEIGHT_WIDTH_DEF     = 8;
  localparam int TILE_COUNT_DEF       = 4;

  localparam int CMD_W  = 2;
  localparam int TILE_W = 2;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_QUEUE  = 2'd1,
    CMD_STREAM = 2'd2,
    CMD_SIZE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              in_range;
    cmd_t              cmd;
    logic [TILE_W-1:0] tile;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } op_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// ----- hdl/weight_stationary_systolic_tile_top.sv -----
// ----------------------------------------------------------------------------
// weight_stationary_systolic_tile_top
// bank of weight-stationary systolic tiles, one per core, driven by bus beats
// ----------------------------------------------------------------------------
// Every command beat yields exactly one result beat. Commands: load weights
// (unpacks weights into the tile's grid and returns the sticky nonzero flag),
// queue input (puts a group of activations on the skew diagonal and returns
// the de-skewed outputs of the next column group), stream step (loads the
// last group, advances every skew line, does all multiply-accumulates of the
// grid at once and returns the first output group) and read size (returns the
// array dimension). One beat is taken per cycle while the queue has room; the
// back end completes each command when it pops it, updating the whole
// processing-element grid of the addressed tile together. An accepted beat
// passes the two-entry command queue, then the output register, to its
// result beat. The input side keeps accepting while a result waits, until the
// queue is full. Tile state clears at reset, with no clearing pass.
module weight_stationary_systolic_tile_top import wsst_pkg::*; #(
  parameter int ARRAY_DIM        = ARRAY_DIM_DEF,
  parameter int ACTS_PER_WORD    = ACTS_PER_WORD_DEF,
  parameter int WEIGHTS_PER_WORD = WEIGHTS_PER_WORD_DEF,
  parameter int ACT_WIDTH        = ACT_WIDTH_DEF,
  parameter int WEIGHT_WIDTH     = WEIGHT_WIDTH_DEF,
  parameter int TILE_COUNT       = TILE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [TILE_W-1:0] in_tile_index,
  input  logic [POS_W-1:0]  in_position,
  input  logic [WORD_W-1:0] in_bus_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_read_data,
  output logic              out_nonzero_flag
);

  // front to queue
  logic    push;
  op_t     push_op;
  // queue to back
  op_t     head_op;
  q_stat_t q_stat;
  logic    pop;

  // accept and classify incoming beats
  wsst_front #(
    .TILE_COUNT(TILE_COUNT)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_tile_index(in_tile_index),
    .in_position  (in_position),
    .in_bus_word  (in_bus_word),
    .q_stat       (q_stat),
    .push         (push),
    .push_op      (push_op)
  );

  // decouples input acceptance from result back-pressure
  wsst_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .head_op(head_op),
    .q_stat (q_stat)
  );

  // tile grids and result register
  wsst_back #(
    .ARRAY_DIM       (ARRAY_DIM),
    .ACTS_PER_WORD   (ACTS_PER_WORD),
    .WEIGHTS_PER_WORD(WEIGHTS_PER_WORD),
    .ACT_WIDTH       (ACT_WIDTH),
    .WEIGHT_WIDTH    (WEIGHT_WIDTH),
    .TILE_COUNT      (TILE_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_op         (head_op),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_nonzero_flag(out_nonzero_flag)
  );

endmodule

// ----- hdl/wsst_front.sv -----
// ----------------------------------------------------------------------------
// wsst_front
// input handshake and command classification
// ----------------------------------------------------------------------------
module wsst_front import wsst_pkg::*; #(
  parameter int TILE_COUNT = TILE_COUNT_DEF
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [TILE_W-1:0] in_tile_index,
  input  logic [POS_W-1:0]  in_position,
  input  logic [WORD_W-1:0] in_bus_word,
  input  q_stat_t           q_stat,
  output logic              push,
  output op_t               push_op
);

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_op.in_range = (int'(in_tile_index) < TILE_COUNT);
    push_op.cmd      = cmd_t'(in_command);
    push_op.tile     = in_tile_index;
    push_op.pos      = in_position;
    push_op.word     = in_bus_word;
  end

endmodule

// ----- hdl/wsst_queue.sv -----
// ----------------------------------------------------------------------------
// wsst_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module wsst_queue import wsst_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     head_op,
  output q_stat_t q_stat
);

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  assign head_op          = mem_r[rd_ptr_r];
  assign q_stat.full      = count_r[1];
  assign q_stat.not_empty = (count_r != 2'd0);

endmodule

// ----- hdl/wsst_tile.sv -----
// ----------------------------------------------------------------------------
// wsst_tile
// one tile: weight grid, skew lines, pe grid and partial sums
// ----------------------------------------------------------------------------
module wsst_tile import wsst_pkg::*; #(
  parameter int ARRAY_DIM        = ARRAY_DIM_DEF,
  parameter int ACTS_PER_WORD    = ACTS_PER_WORD_DEF,
  parameter int WEIGHTS_PER_WORD = WEIGHTS_PER_WORD_DEF,
  parameter int ACT_WIDTH        = ACT_WIDTH_DEF,
  parameter int WEIGHT_WIDTH     = WEIGHT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  op_t               op,
  output logic [WORD_W-1:0] res_data,
  output logic              res_flag
);

  localparam int K      = ARRAY_DIM;
  localparam int Apw    = ACTS_PER_WORD;
  localparam int Wpw    = WEIGHTS_PER_WORD;
  localparam int AW     = ACT_WIDTH;
  localparam int WW     = WEIGHT_WIDTH;
  localparam int Groups = (K + Apw - 1) / Apw;
  localparam int CW     = $clog2(K);

  logic [WW-1:0] w_r   [K][K];
  logic [WW-1:0] w_nxt [K][K];
  logic [AW-1:0] isk_r [K][K];
  logic [AW-1:0] isk_plc [K][K];
  logic [AW-1:0] isk_str [K][K];
  logic [AW-1:0] pe_r  [K][K];
  logic [AW-1:0] act   [K][K];
  logic [AW-1:0] pe_str [K][K];
  logic [31:0]   ps_r  [K][K];
  logic [31:0]   ps_str [K][K];
  logic [AW-1:0] osk_r [K][K];
  logic [AW-1:0] osk_str [K][K];
  logic [AW-1:0] diag_old [K];
  logic [AW-1:0] diag_new [K];
  logic signed [AW+WW-1:0] prod [K][K];
  logic          nz_r;
  logic [POS_W-1:0] grp;
  logic [CW-1:0] qbase;

  function automatic logic [AW-1:0] unpack_a(input logic [31:0] w, input int i);
    int          sh;
    logic [31:0] s;
    sh = AW * (Apw - 1 - i);
    s  = w >> sh;
    return (sh + AW > 32) ? '0 : s[AW-1:0];
  endfunction

  function automatic logic [WW-1:0] unpack_w(input logic [31:0] w, input int i);
    int          sh;
    logic [31:0] s;
    sh = WW * (Wpw - 1 - i);
    s  = w >> sh;
    return (sh + WW > 32) ? '0 : s[WW-1:0];
  endfunction

  // base column of the group after the queued one
  function automatic logic [CW-1:0] q_base(input logic [POS_W-1:0] p);
    logic [CW-1:0] q;
    q = '0;
    for (int k = 0; k < (1 << POS_W); k++) begin
      if (p == POS_W'(k)) q = CW'(((k + 1) % Groups) * Apw);
    end
    return q;
  endfunction

  function automatic logic [31:0] gather(input logic [AW-1:0] d [K],
                                         input logic [CW-1:0] base);
    logic [31:0] r;
    int          sh;
    r = '0;
    for (int i = 0; i < Apw; i++) begin
      sh = AW * (Apw - 1 - i);
      for (int k = 0; k < K; k++) begin
        if ((int'(base) + i == k) && (sh + AW <= 32)) r = r | (32'(d[k]) << sh);
      end
    end
    return r;
  endfunction

  assign grp   = (op.cmd == CMD_QUEUE) ? op.pos : POS_W'(Groups - 1);
  assign qbase = q_base(op.pos);

  // weight writes
  always_comb begin
    w_nxt = w_r;
    for (int r = 0; r < K; r++) begin
      for (int c = 0; c < K; c++) begin
        for (int i = 0; i < Wpw; i++) begin
          if (int'(op.pos) + i == r * K + c) w_nxt[r][c] = unpack_w(op.word, i);
        end
      end
    end
  end

  // group onto the skew diagonal
  always_comb begin
    isk_plc = isk_r;
    for (int r = 0; r < K; r++) begin
      for (int i = 0; i < Apw; i++) begin
        if (int'(grp) * Apw + i == r) isk_plc[r][K-1-r] = unpack_a(op.word, i);
      end
    end
  end

  // one systolic step
  always_comb begin
    for (int r = 0; r < K; r++) begin
      isk_str[r][0] = isk_plc[r][0];
      for (int c = 1; c < K; c++) isk_str[r][c] = isk_plc[r][c-1];
      for (int c = 0; c < K; c++) act[r][c] = (c == 0) ? isk_plc[r][K-1] : pe_r[r][c];
      pe_str[r][0] = act[r][0];
      for (int c = 1; c < K; c++) pe_str[r][c] = act[r][c-1];
      for (int c = 0; c < K; c++) begin
        prod[r][c]   = $signed(act[r][c]) * $signed(w_r[r][c]);
        ps_str[r][c] = 32'(prod[r][c]) + ((r == 0) ? 32'd0 : ps_r[(r == 0) ? 0 : r-1][c]);
      end
    end
    for (int c = 0; c < K; c++) begin
      osk_str[0][c] = ps_str[K-1][c][AW-1:0];
      for (int r = 1; r < K; r++) osk_str[r][c] = osk_r[r-1][c];
    end
    for (int c = 0; c < K; c++) begin
      diag_old[c] = osk_r[K-1-c][c];
      diag_new[c] = osk_str[K-1-c][c];
    end
  end

  always_comb begin
    res_data = '0;
    res_flag = 1'b0;
    case (op.cmd)
      CMD_LOAD:   res_flag = nz_r || (op.word != '0);
      CMD_QUEUE:  res_data = gather(diag_old, qbase);
      CMD_STREAM: res_data = gather(diag_new, '0);
      default:    res_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r <= 1'b0;
      for (int r = 0; r < K; r++) begin
        for (int c = 0; c < K; c++) begin
          w_r[r][c]   <= '0;
          isk_r[r][c] <= '0;
          pe_r[r][c]  <= '0;
          ps_r[r][c]  <= '0;
          osk_r[r][c] <= '0;
        end
      end
    end else if (en) begin
      case (op.cmd)
        CMD_LOAD: begin
          w_r  <= w_nxt;
          nz_r <= nz_r || (op.word != '0);
        end
        CMD_QUEUE: begin
          isk_r <= isk_plc;
        end
        CMD_STREAM: begin
          isk_r <= isk_str;
          pe_r  <= pe_str;
          ps_r  <= ps_str;
          osk_r <= osk_str;
          nz_r  <= 1'b0;
        end
        default: begin
          nz_r <= nz_r;
        end
      endcase
    end
  end

endmodule

// ----- hdl/wsst_back.sv -----
// ----------------------------------------------------------------------------
// wsst_back
// executes queued commands on the tiles and holds the result beat
// ----------------------------------------------------------------------------
module wsst_back import wsst_pkg::*; #(
  parameter int ARRAY_DIM        = ARRAY_DIM_DEF,
  parameter int ACTS_PER_WORD    = ACTS_PER_WORD_DEF,
  parameter int WEIGHTS_PER_WORD = WEIGHTS_PER_WORD_DEF,
  parameter int ACT_WIDTH        = ACT_WIDTH_DEF,
  parameter int WEIGHT_WIDTH     = WEIGHT_WIDTH_DEF,
  parameter int TILE_COUNT       = TILE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  op_t               head_op,
  input  q_stat_t           q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_read_data,
  output logic              out_nonzero_flag
);

  logic [WORD_W-1:0] tile_data [TILE_COUNT];
  logic              tile_flag [TILE_COUNT];
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] data_r, data_nxt;
  logic              flag_r, flag_nxt;

  assign pop = q_stat.not_empty && (!out_valid_r || out_ready);

  for (genvar t = 0; t < TILE_COUNT; t++) begin : g_tile
    wsst_tile #(
      .ARRAY_DIM       (ARRAY_DIM),
      .ACTS_PER_WORD   (ACTS_PER_WORD),
      .WEIGHTS_PER_WORD(WEIGHTS_PER_WORD),
      .ACT_WIDTH       (ACT_WIDTH),
      .WEIGHT_WIDTH    (WEIGHT_WIDTH)
    ) u_tile (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pop && head_op.in_range && (int'(head_op.tile) == t)),
      .op      (head_op),
      .res_data(tile_data[t]),
      .res_flag(tile_flag[t])
    );
  end

  always_comb begin
    out_valid_nxt = pop ? 1'b1 : (out_valid_r && !out_ready);
    data_nxt      = '0;
    flag_nxt      = 1'b0;
    if (head_op.in_range) begin
      if (head_op.cmd == CMD_SIZE) begin
        data_nxt = WORD_W'(ARRAY_DIM);
      end else begin
        for (int t = 0; t < TILE_COUNT; t++) begin
          if (int'(head_op.tile) == t) begin
            data_nxt = tile_data[t];
            flag_nxt = tile_flag[t];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= data_nxt;
      flag_r <= flag_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = data_r;
  assign out_nonzero_flag = flag_r;

endmodule

// ----- hdl/wsst_checker.sv -----
// ----------------------------------------------------------------------------
// wsst_checker
// port-level checks on the systolic tile bank
// ----------------------------------------------------------------------------
`include "weight_stationary_systolic_tile_top_assert.svh"

module wsst_checker import wsst_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_read_data,
  input logic              out_nonzero_flag
);

  // held result beat keeps its payload
  `WSST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_data) && $stable(out_nonzero_flag))

  // only a load raises the flag, and a load returns no data
  `WSST_ASSERT_NOW(a_flag_no_data, out_valid && out_nonzero_flag, out_read_data == '0)

  // the queue only fills behind a waiting result
  `WSST_ASSERT_NOW(a_full_stalled, !in_ready, out_valid)

  // nothing comes out straight after reset
  `WSST_ASSERT_NEXT_RST(a_reset_idle, !rst_n, !out_valid)

endmodule

bind weight_stationary_systolic_tile_top wsst_checker u_wsst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_read_data   (out_read_data),
  .out_nonzero_flag(out_nonzero_flag)
);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// systolic tile bank testbench
// drives random and directed command beats into the tile bank, predicts every
// result beat with a scoreboard model of the tiles and checks them in order
// ----------------------------------------------------------------------------
module tb;
  import wsst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM    = ARRAY_DIM_DEF;
  localparam int PER    = ACTS_PER_WORD_DEF;
  localparam int WPER   = WEIGHTS_PER_WORD_DEF;
  localparam int AW     = ACT_WIDTH_DEF;
  localparam int WW     = WEIGHT_WIDTH_DEF;
  localparam int TILES  = TILE_COUNT_DEF;
  localparam int CELLS  = DIM * DIM;
  localparam int GROUPS = (DIM + PER - 1) / PER;
  localparam int LIMIT  = 400000;

  typedef struct {
    logic [WORD_W-1:0] data;
    logic              flag;
  } result_t;

  int errors = 0;

  // one line per mismatch, counted
  task automatic report(string what);
    errors++;
    $display("ERROR %0t: %s", $time, what);
  endtask

  // tile bank model and queue of predicted result beats
  class tile_scoreboard;
    logic [WW-1:0]     weights [TILES][CELLS];
    logic [AW-1:0]     skew_in [TILES][CELLS];
    logic [AW-1:0]     acts    [TILES][CELLS];
    logic [31:0]       psum    [TILES][CELLS+DIM];
    logic [AW-1:0]     skew_out[TILES][CELLS];
    bit                nonzero [TILES];
    result_t           pending[$];

    function new();
      for (int t = 0; t < TILES; t++) begin
        nonzero[t] = 0;
        for (int i = 0; i < CELLS; i++) begin
          weights[t][i] = '0; skew_in[t][i] = '0; acts[t][i] = '0; skew_out[t][i] = '0;
        end
        for (int i = 0; i < CELLS + DIM; i++) psum[t][i] = '0;
      end
    endfunction

    function automatic logic [31:0] slot_of(logic [31:0] w, int s, int per, int width);
      int sh;
      sh = width * (per - 1 - s);
      if (sh + width > 32) return 0;
      return (w >> sh) & ((32'd1 << width) - 1);
    endfunction

    function automatic void place(int t, int grp, logic [31:0] w);
      int row;
      for (int i = 0; i < PER; i++) begin
        row = grp * PER + i;
        if (row < DIM) skew_in[t][row*DIM + DIM-1-row] = AW'(slot_of(w, i, PER, AW));
      end
    endfunction

    function automatic logic [31:0] gather(int t, int base);
      logic [31:0] r;
      int c, sh;
      r = 0;
      for (int i = 0; i < PER; i++) begin
        c = base + i;
        sh = AW * (PER - 1 - i);
        if (c < DIM && sh + AW <= 32) r |= 32'(skew_out[t][(DIM-1-c)*DIM + c]) << sh;
      end
      return r;
    endfunction

    function automatic logic [31:0] stream(int t, logic [31:0] w);
      logic signed [31:0] p;
      nonzero[t] = 0;
      place(t, GROUPS - 1, w);
      for (int i = 0; i < DIM; i++) begin
        acts[t][i*DIM] = skew_in[t][i*DIM + DIM-1];
        for (int j = DIM-1; j > 0; j--) skew_in[t][i*DIM+j] = skew_in[t][i*DIM+j-1];
      end
      // bottom-up so every cell adds the sum from above as it was
      for (int i = CELLS-1; i >= 0; i--) begin
        p = $signed(acts[t][i]) * $signed(weights[t][i]);
        psum[t][i+DIM] = p + psum[t][i];
      end
      for (int i = 0; i < DIM; i++)
        for (int j = DIM-1; j > 0; j--) acts[t][i*DIM+j] = acts[t][i*DIM+j-1];
      for (int j = 0; j < DIM; j++) begin
        for (int i = DIM-1; i > 0; i--) skew_out[t][i*DIM+j] = skew_out[t][(i-1)*DIM+j];
        skew_out[t][j] = AW'(psum[t][CELLS+j]);
      end
      return gather(t, 0);
    endfunction

    function automatic void note_input(cmd_t cmd, int t, int pos, logic [31:0] w);
      result_t r;
      r.data = 0; r.flag = 0;
      if (t < TILES) begin
        case (cmd)
          CMD_LOAD: begin
            for (int i = 0; i < WPER; i++)
              if (pos + i < CELLS) weights[t][pos+i] = WW'(slot_of(w, i, WPER, WW));
            if (w != 0) nonzero[t] = 1;
            r.flag = nonzero[t];
          end
          CMD_QUEUE: begin
            place(t, pos, w);
            r.data = gather(t, ((pos + 1) % GROUPS) * PER);
          end
          CMD_STREAM: r.data = stream(t, w);
          default:    r.data = DIM;
        endcase
      end
      pending.insert(pending.size(), r);
    endfunction

    task automatic check_result(logic [31:0] data, logic flag);
      result_t e;
      if (pending.size() == 0) begin
        report($sformatf("result beat with nothing expected, data %h", data));
        return;
      end
      e = pending.pop_front();
      if (data !== e.data) report($sformatf("read_data %h, expected %h", data, e.data));
      if (flag !== e.flag) report($sformatf("nonzero_flag %b, expected %b", flag, e.flag));
    endtask
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command = '0;
  logic [TILE_W-1:0] in_tile_index = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic [WORD_W-1:0] in_bus_word = '0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [WORD_W-1:0] out_read_data;
  logic              out_nonzero_flag;

  weight_stationary_systolic_tile_top i_dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  tile_scoreboard sb = new();
  int  cycle = 0;
  int  sent  = 0;   // input beats accepted so far
  bit  quiet = 0;   // long stretch with no idling on either side
  bit  hold  = 0;   // receiver held off to fill the block up

  always @(posedge clk) begin
    cycle++;
    if (cycle > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // sample the result channel at the rising edge
  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_read_data, out_nonzero_flag);

  // receiver: random stalls, none in the quiet stretch, none taken while held
  always @(negedge clk) begin
    if (hold) out_ready <= 0;
    else out_ready <= quiet || ($urandom_range(99) >= 24);
  end

  // offers one beat, idles at random first, then waits for acceptance
  task automatic send(cmd_t cmd, logic [1:0] t, logic [5:0] pos, logic [31:0] w);
    while (!quiet && $urandom_range(99) < 24) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid      <= 1;
    in_command    <= cmd;
    in_tile_index <= t;
    in_position   <= pos;
    in_bus_word   <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_input(cmd, t, pos, w);
    sent++;
    @(negedge clk);
  endtask

  // typical computation: weights, activations on each group, several stream beats
  task automatic run_sequence();
    logic [1:0] t;
    t = 2'($urandom_range(TILES-1));
    for (int p = 0; p < CELLS; p += WPER)
      if ($urandom_range(3) != 0) send(CMD_LOAD, t, 6'(p), $urandom);
    for (int k = 0; k < 4; k++) begin
      for (int g = 0; g < GROUPS; g++) send(CMD_QUEUE, t, 6'(g), $urandom);
      send(CMD_STREAM, t, 6'($urandom_range(63)), $urandom);
    end
  endtask

  task automatic random_beat();
    send(cmd_t'($urandom_range(3)), 2'($urandom_range(3)), 6'($urandom_range(63)), $urandom);
  endtask

  // pressure: hold the receiver off for a long count while beats keep coming
  initial begin
    wait (rst_n);
    repeat (300) @(negedge clk);
    hold = 1;
    repeat (60) @(negedge clk);
    hold = 0;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, every command, out-of-range slots and group wrap
    send(CMD_SIZE,   2'd0, 6'd0,  32'h0);
    send(CMD_LOAD,   2'd1, 6'd0,  32'h0);            // zero word leaves the flag clear
    send(CMD_LOAD,   2'd1, 6'd0,  32'h7F80FF01);
    send(CMD_LOAD,   2'd1, 6'd62, 32'hFFFFFFFF);     // slots past the store are dropped
    send(CMD_LOAD,   2'd1, 6'd63, 32'h80808080);
    send(CMD_LOAD,   2'd1, 6'd4,  32'h0);            // flag stays set
    send(CMD_QUEUE,  2'd1, 6'd0,  32'h80FF7F01);
    send(CMD_QUEUE,  2'd1, 6'd1,  32'h7F7F7F7F);     // wraps back to group zero
    send(CMD_QUEUE,  2'd1, 6'd5,  32'hFFFFFFFF);     // rows past the array dropped
    send(CMD_QUEUE,  2'd1, 6'd63, 32'h12345678);
    for (int i = 0; i < 10; i++) send(CMD_STREAM, 2'd1, 6'(i), 32'h80808080);
    send(CMD_STREAM, 2'd2, 6'd63, 32'hFFFFFFFF);
    send(CMD_SIZE,   2'd3, 6'd63, 32'hFFFFFFFF);
    send(CMD_LOAD,   2'd3, 6'd0,  32'h55AA55AA);
    send(CMD_LOAD,   2'd2, 6'd32, 32'hAA55AA55);

    while (sent < 600) begin
      quiet = (sent >= 300 && sent < 380);
      if ($urandom_range(3) != 0) run_sequence();
      else random_beat();
    end
    quiet = 0;
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
